### hdl/modular_exponentiation_unit_macros.svh
// Assertion macros for the checker file of the exponentiation unit.
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MEXP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define MEXP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/mexp_pkg.sv
// Shared command and status types for the exponentiation controller and datapath.
package mexp_pkg;

    // Datapath commands, at most one high per cycle.
    typedef struct packed {
        logic load;         // capture a new request
        logic reduce_step;  // one bit of base mod modulus
        logic mul_start;    // clear partial products, load multiplier
        logic mul_step;     // one multiplier bit of both products
        logic mul_end;      // retire both products, prepare next bit
        logic out_load;     // move result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic mod_small;    // modulus is 0 or 1
    } t_dp_status;

endpackage

### hdl/mexp_ctrl.sv
// Sequencer for the exponentiation unit: handshakes, counters and datapath commands.
module mexp_ctrl
    import mexp_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_MSTART = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_MEND   = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;     // multiplier / reduction bit
    logic [CW-1:0] r_ecnt, n_ecnt;   // exponent bit
    logic          r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ecnt      = r_ecnt;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cnt   = LAST;
                n_ecnt  = LAST;
                n_state = i_status.mod_small ? S_FINISH : S_REDUCE;
            end
            S_REDUCE: begin
                o_cmd.reduce_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MSTART;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_MSTART: begin
                o_cmd.mul_start = 1'b1;
                n_cnt           = LAST;
                n_state         = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == '0) begin
                    n_cnt   = LAST;
                    n_state = S_MEND;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_MEND: begin
                o_cmd.mul_end = 1'b1;
                if (r_ecnt == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_ecnt  = r_ecnt - 1'b1;
                    n_state = S_MUL;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_ecnt      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_ecnt      <= n_ecnt;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/mexp_dp.sv
// Datapath: operand registers, two interleaved modular multipliers and the result register.
module mexp_dp
    import mexp_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_status,
    input  logic [WIDTH-1:0] i_base,
    input  logic [WIDTH-1:0] i_exponent,
    input  logic [WIDTH-1:0] i_modulus,
    output logic [WIDTH-1:0] o_power_mod,
    output logic             o_bad_modulus
);

    // (2*r + a) mod m for r < m, a < m (input below 3m).
    function automatic logic [WIDTH-1:0] f_step(input logic [WIDTH-1:0] r,
                                                input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] m);
        logic [WIDTH+1:0] s;
        logic [WIDTH+1:0] d1;
        logic [WIDTH+1:0] d2;
        s  = {1'b0, r, 1'b0} + {2'b00, a};
        d1 = s - {2'b00, m};
        d2 = s - {1'b0, m, 1'b0};
        if (!d2[WIDTH+1]) begin
            f_step = d2[WIDTH-1:0];
        end else if (!d1[WIDTH+1]) begin
            f_step = d1[WIDTH-1:0];
        end else begin
            f_step = s[WIDTH-1:0];
        end
    endfunction

    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_base;    // reduced base, squared per exponent bit
    logic [WIDTH-1:0] r_acc;     // running result
    logic [WIDTH-1:0] r_pa;      // partial acc * base
    logic [WIDTH-1:0] r_pb;      // partial base * base
    logic [WIDTH-1:0] r_mplier;  // MSB-first scan: raw base, then base
    logic [WIDTH-1:0] r_exp;
    logic             r_small;
    logic             r_zero;
    logic [WIDTH-1:0] r_out;
    logic             r_out_bad;

    logic             w_msb;
    logic [WIDTH-1:0] w_pa_next;
    logic [WIDTH-1:0] w_pb_next;
    logic [WIDTH-1:0] w_red_next;

    assign w_msb      = r_mplier[WIDTH-1];
    assign w_pa_next  = f_step(r_pa, w_msb ? r_acc  : '0, r_mod);
    assign w_pb_next  = f_step(r_pb, w_msb ? r_base : '0, r_mod);
    assign w_red_next = f_step(r_base, {{(WIDTH-1){1'b0}}, w_msb}, r_mod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mod    <= i_modulus;
            r_mplier <= i_base;
            r_exp    <= i_exponent;
            r_base   <= '0;
            r_acc    <= {{(WIDTH-1){1'b0}}, 1'b1};
            r_small  <= (i_modulus[WIDTH-1:1] == '0);
            r_zero   <= (i_modulus == '0);
        end
        if (i_cmd.reduce_step) begin
            r_base   <= w_red_next;
            r_mplier <= {r_mplier[WIDTH-2:0], 1'b0};
        end
        if (i_cmd.mul_start) begin
            r_pa     <= '0;
            r_pb     <= '0;
            r_mplier <= r_base;
        end
        if (i_cmd.mul_step) begin
            r_pa     <= w_pa_next;
            r_pb     <= w_pb_next;
            r_mplier <= {r_mplier[WIDTH-2:0], 1'b0};
        end
        if (i_cmd.mul_end) begin
            if (r_exp[0]) begin
                r_acc <= r_pa;
            end
            r_base   <= r_pb;
            r_mplier <= r_pb;
            r_pa     <= '0;
            r_pb     <= '0;
            r_exp    <= {1'b0, r_exp[WIDTH-1:1]};
        end
        if (i_cmd.out_load) begin
            r_out     <= r_small ? '0 : r_acc;
            r_out_bad <= r_zero;
        end
    end

    assign o_status.mod_small = r_small;
    assign o_power_mod        = r_out;
    assign o_bad_modulus      = r_out_bad;

endmodule

### hdl/modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit: controller, datapath and ports.
//
// Computes base^exponent mod modulus for unsigned WIDTH-bit operands by the
// right-to-left binary method. A request is taken on i_in_valid/o_in_ready;
// the unit works on one request at a time and raises o_in_ready again once
// the result has moved into the output register, so the next request can be
// accepted while that result still waits for i_out_ready. The base is first
// reduced one bit per cycle; then each of the WIDTH exponent bits runs two
// interleaved shift-and-add modular multipliers side by side (acc*base and
// base*base, one multiplier bit per cycle) and then retires them. A modulus
// of 0 or 1 bypasses the arithmetic and finishes with power_mod = 0; a zero
// modulus also sets o_bad_modulus. An exponent of 0 gives 1 for any modulus
// above 1. All products stay exact: every partial sum is reduced before it
// can exceed WIDTH+2 bits.
module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [WIDTH-1:0] i_base,
    input  logic [WIDTH-1:0] i_exponent,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-1:0] o_power_mod,
    output logic             o_bad_modulus
);

    t_dp_cmd    w_cmd;     // controller -> datapath
    t_dp_status w_status;  // datapath -> controller

    mexp_ctrl #(
        .WIDTH(WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    mexp_dp #(
        .WIDTH(WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_base        (i_base),
        .i_exponent    (i_exponent),
        .i_modulus     (i_modulus),
        .o_power_mod   (o_power_mod),
        .o_bad_modulus (o_bad_modulus)
    );

endmodule

### hdl/mexp_checker.sv
// Port-level checker for the exponentiation unit, bound to the top level.
`include "modular_exponentiation_unit_macros.svh"

module mexp_checker #(
    parameter int WIDTH = 64
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic [WIDTH-1:0] i_base,
    input logic [WIDTH-1:0] i_exponent,
    input logic [WIDTH-1:0] i_modulus,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [WIDTH-1:0] o_power_mod,
    input logic             o_bad_modulus
);

    // A stalled result stays offered.
    `MEXP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // A stalled result keeps its payload.
    `MEXP_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_power_mod) && $stable(o_bad_modulus))

    // Zero modulus always reports a zero power.
    `MEXP_ASSERT_NOW(a_bad_zero, o_out_valid && o_bad_modulus, o_power_mod == '0)

    // One request in flight: busy right after an accept.
    `MEXP_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind modular_exponentiation_unit mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the modular exponentiation unit.
module testbench;

    localparam int WIDTH = 64;
    // Budget covers the slowest requests plus gaps and stalls; 140 requests in all.
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_CYCLES = 16;

    // Expected result of one request, operands kept for the mismatch message.
    typedef struct {
        logic [WIDTH-1:0] base;
        logic [WIDTH-1:0] exponent;
        logic [WIDTH-1:0] modulus;
        logic [WIDTH-1:0] power_mod;
        logic             bad_modulus;
    } t_power_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [WIDTH-1:0] i_base = '0;
    logic [WIDTH-1:0] i_exponent = '0;
    logic [WIDTH-1:0] i_modulus = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b1;
    logic [WIDTH-1:0] o_power_mod;
    logic             o_bad_modulus;

    t_power_result pending_results[$];
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;
    bit            idle_on = 1'b1;

    modular_exponentiation_unit #(
        .WIDTH(WIDTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_base       (i_base),
        .i_exponent   (i_exponent),
        .i_modulus    (i_modulus),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_power_mod  (o_power_mod),
        .o_bad_modulus(o_bad_modulus)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Right-to-left binary exponentiation. Products are taken exactly at double
    // width and reduced, which matches the unit's interleaved multiply.
    function automatic t_power_result compute_power_mod(logic [WIDTH-1:0] base,
                                                        logic [WIDTH-1:0] exponent,
                                                        logic [WIDTH-1:0] modulus);
        t_power_result        res;
        logic [2*WIDTH-1:0]   prod;
        logic [WIDTH-1:0]     acc;
        logic [WIDTH-1:0]     sq;
        res.base        = base;
        res.exponent    = exponent;
        res.modulus     = modulus;
        res.power_mod   = '0;
        res.bad_modulus = (modulus == '0);
        if (modulus > 1) begin
            acc = WIDTH'(1);
            sq  = base % modulus;
            for (int i = 0; i < WIDTH; i++) begin
                if (exponent[i]) begin
                    prod = (2*WIDTH)'(acc) * (2*WIDTH)'(sq);
                    acc  = WIDTH'(prod % (2*WIDTH)'(modulus));
                end
                prod = (2*WIDTH)'(sq) * (2*WIDTH)'(sq);
                sq   = WIDTH'(prod % (2*WIDTH)'(modulus));
            end
            res.power_mod = acc;
        end
        return res;
    endfunction

    function automatic logic [WIDTH-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Random value of the given bit length (1..WIDTH).
    function automatic logic [WIDTH-1:0] rand_bits(int nbits);
        return rand_word() >> (WIDTH - nbits);
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Drive one request and hold it until the unit takes it. An optional gap
    // of idle cycles goes in front while idling is on.
    task automatic send_request(logic [WIDTH-1:0] base, logic [WIDTH-1:0] exponent,
                                logic [WIDTH-1:0] modulus);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_base     <= base;
        i_exponent <= exponent;
        i_modulus  <= modulus;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.insert(pending_results.size(),
                               compute_power_mod(base, exponent, modulus));
    endtask

    // Result side back-pressure: random stall bursts while idling is on.
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_power_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result power_mod=%h bad=%b",
                                          o_power_mod, o_bad_modulus));
            end else begin
                exp_res = pending_results.pop_front();
                if (o_power_mod !== exp_res.power_mod)
                    report_mismatch($sformatf("b=%h e=%h m=%h power_mod %h exp %h",
                                              exp_res.base, exp_res.exponent,
                                              exp_res.modulus, o_power_mod,
                                              exp_res.power_mod));
                if (o_bad_modulus !== exp_res.bad_modulus)
                    report_mismatch($sformatf("m=%h bad_modulus %b exp %b",
                                              exp_res.modulus, o_bad_modulus,
                                              exp_res.bad_modulus));
            end
        end
    end

    // Corner operands: zero and unit modulus, zero exponent, all-ones fields,
    // base above modulus, even and odd large moduli.
    task automatic test_special_cases();
        logic [WIDTH-1:0] ones;
        ones = '1;
        send_request(64'd5, 64'd3, 64'd0);                  // zero modulus flags error
        send_request(ones, ones, 64'd0);
        send_request(ones, ones, 64'd1);                    // unit modulus
        send_request(64'd0, 64'd0, 64'd7);                  // 0^0 gives 1
        send_request(64'd123, 64'd0, ones);
        send_request(64'd0, 64'd9, 64'd13);
        send_request(ones, ones, ones);
        send_request(ones, ones, 64'd2);
        send_request(64'd1000, 64'd1, 64'd17);              // base above modulus
        send_request(64'd2, 64'd63, ones);
        send_request(64'd3, ones, 64'h8000_0000_0000_0000);
        // Fermat check with the largest 64-bit prime: a^(p-1) = 1
        send_request(64'h1234_5678_9abc_def0, 64'hFFFF_FFFF_FFFF_FFC4,
                     64'hFFFF_FFFF_FFFF_FFC5);
        send_request(ones - 1, 64'd2, ones);
        send_request(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'd3);
        send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                     64'hAAAA_AAAA_AAAA_AAAB);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                     64'h5555_5555_5555_5555);
    endtask

    // One random request from a mix of operand shapes.
    task automatic send_random_request();
        logic [WIDTH-1:0] base;
        logic [WIDTH-1:0] exponent;
        logic [WIDTH-1:0] modulus;
        base     = rand_word();
        exponent = rand_word();
        modulus  = rand_word();
        case ($urandom_range(0, 9))
            4, 5: begin
                modulus  = rand_bits($urandom_range(1, WIDTH));
                exponent = rand_bits($urandom_range(1, WIDTH));
            end
            6: modulus = WIDTH'($urandom_range(2, 1000));
            7: modulus = WIDTH'($urandom_range(0, 1));
            8: exponent = WIDTH'($urandom_range(0, 20));
            9: begin
                modulus    = rand_word();
                modulus[WIDTH-1] = 1'b1;
                base       = modulus - WIDTH'($urandom_range(0, 3));
            end
            default: ;
        endcase
        send_request(base, exponent, modulus);
    endtask

    task automatic test_random_requests();
        repeat (104) send_random_request();
    endtask

    // Last stretch: no input gaps and no result stalls.
    task automatic test_back_to_back();
        i_in_valid <= 1'b0;
        idle_on = 1'b0;
        @(posedge i_clk);
        while (!i_out_ready) @(posedge i_clk);
        repeat (20) send_random_request();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_random_requests();
        test_back_to_back();
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/mexp_pkg.sv
hdl/mexp_ctrl.sv
hdl/mexp_dp.sv
hdl/modular_exponentiation_unit.sv
hdl/mexp_checker.sv
tb/testbench.sv
